>>> rtl/qte_pkg.sv
// Shared types and constants for the quaternion to Euler angle pipeline.
`timescale 1ns / 1ps
package qte_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_TABLE_LEN    = 25;
   localparam int CORDIC_STAGES     = (CORDIC_ITERATIONS < ATAN_TABLE_LEN) ?
                                      CORDIC_ITERATIONS : ATAN_TABLE_LEN;

   // Q28 sums of products: |value| <= 2^32
   localparam int TERM_W     = 34;
   // 1 - s^2 at Q56 and its floor square root at Q28
   localparam int REM_W      = 57;
   localparam int ROOT_W     = 29;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int ATAN_IN_W  = 35;
   // CORDIC datapath, larger operand magnitude normalized to [2^57, 2^58)
   localparam int CW         = 64;
   localparam int NORM_TOP   = 57;
   localparam int ZW         = 28;
   localparam int ATAN_LAT   = CORDIC_STAGES + 4;

   localparam logic signed [TERM_W-1:0] ONE_Q28 = {{(TERM_W-29){1'b0}}, 1'b1, 28'b0};
   localparam logic [REM_W-1:0]         ONE_Q56 = {1'b1, {(REM_W-1){1'b0}}};
   localparam logic signed [ZW-1:0]     PI_Q24  = 28'sd52707179;
   localparam logic signed [15:0]       PI_Q13      = 16'sd25736;
   localparam logic signed [15:0]       HALF_PI_Q13 = 16'sd12868;

   localparam logic [ZW-1:0] ATAN_TABLE [ATAN_TABLE_LEN] = '{
      28'd13176795, 28'd7778716, 28'd4110060, 28'd2086331, 28'd1047214,
      28'd524117, 28'd262123, 28'd131069, 28'd65536, 28'd32768,
      28'd16384, 28'd8192, 28'd4096, 28'd2048, 28'd1024, 28'd512,
      28'd256, 28'd128, 28'd64, 28'd32, 28'd16, 28'd8, 28'd4, 28'd2, 28'd1
   };

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } quat_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
      logic               pitch_clamped;
   } euler_type;

   typedef struct packed {
      logic signed [TERM_W-1:0] sinr;
      logic signed [TERM_W-1:0] cosr;
      logic signed [TERM_W-1:0] sinp;
      logic signed [TERM_W-1:0] siny;
      logic signed [TERM_W-1:0] cosy;
      logic                     clamp;
   } terms_type;

endpackage

>>> rtl/quaternion_to_euler_angles.sv
// Pipeline: 4 term stages, one square-root stage per root bit (29), then atan2
// fold/normalize/CORDIC/round stages and one output register.
// Throughput: one transaction per cycle while the output is not stalled; every stage
// is a register. A stalled output freezes the whole pipeline.
// Reset clears the valid bits only; the datapath registers are not reset.
`timescale 1ns / 1ps
module quaternion_to_euler_angles (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  qte_pkg::quat_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qte_pkg::euler_type rsp_data
);
   import qte_pkg::*;

   logic                       en;
   logic                       terms_valid, sqrt_valid, roll_valid;
   terms_type                  terms, sq_terms;
   logic [REM_W-1:0]           rem;
   logic [ROOT_W-1:0]          root;
   logic signed [15:0]         roll, pitch, yaw;
   logic [1:0]                 pitch_tag;
   logic                       rsp_valid_ff;
   euler_type                  rsp_data_ff, rsp_data_in;

   assign en        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;

   qte_terms u_terms (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (terms_valid),
      .out_terms (terms),
      .out_rem   (rem)
   );

   qte_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (terms_valid),
      .in_terms  (terms),
      .in_rem    (rem),
      .out_valid (sqrt_valid),
      .out_terms (sq_terms),
      .out_root  (root)
   );

   qte_atan2 u_roll (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_y      (ATAN_IN_W'(sq_terms.sinr)),
      .in_x      (ATAN_IN_W'(sq_terms.cosr)),
      .in_tag    (2'b00),
      .out_valid (roll_valid),
      .out_angle (roll),
      .out_tag   ()
   );

   // tag carries the clamp flag and the sign of the pitch term
   qte_atan2 u_pitch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_y      (ATAN_IN_W'(sq_terms.sinp)),
      .in_x      (ATAN_IN_W'(root)),
      .in_tag    ({sq_terms.clamp, ~sq_terms.sinp[TERM_W-1]}),
      .out_valid (),
      .out_angle (pitch),
      .out_tag   (pitch_tag)
   );

   qte_atan2 u_yaw (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sqrt_valid),
      .in_y      (ATAN_IN_W'(sq_terms.siny)),
      .in_x      (ATAN_IN_W'(sq_terms.cosy)),
      .in_tag    (2'b00),
      .out_valid (),
      .out_angle (yaw),
      .out_tag   ()
   );

   always_comb begin
      rsp_data_in.roll_angle    = roll;
      rsp_data_in.yaw_angle     = yaw;
      rsp_data_in.pitch_clamped = pitch_tag[1];
      if (pitch_tag[1]) begin
         rsp_data_in.pitch_angle = pitch_tag[0] ? HALF_PI_Q13 : -HALF_PI_Q13;
      end else begin
         rsp_data_in.pitch_angle = pitch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= roll_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.pitch_clamped |->
         (rsp_data_ff.pitch_angle == HALF_PI_Q13 || rsp_data_ff.pitch_angle == -HALF_PI_Q13))
      else $error("clamped pitch is not +-pi/2");

   a_roll_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.roll_angle <= PI_Q13 && rsp_data_ff.roll_angle >= -PI_Q13))
      else $error("roll outside +-pi");

   a_yaw_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_data_ff.yaw_angle <= PI_Q13 && rsp_data_ff.yaw_angle >= -PI_Q13))
      else $error("yaw outside +-pi");

endmodule

>>> rtl/qte_terms.sv
// Products, trig terms, pitch clamp test and 1 - s^2 in four stages.
`timescale 1ns / 1ps
module qte_terms (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  qte_pkg::quat_type        in_data,
   output logic                     out_valid,
   output qte_pkg::terms_type       out_terms,
   output logic [qte_pkg::REM_W-1:0] out_rem
);
   import qte_pkg::*;

   logic [3:0] valid_ff;

   logic signed [31:0] wx_ff, yz_ff, xx_ff, yy_ff, zz_ff, wy_ff, zx_ff, wz_ff, xy_ff;
   terms_type          tb_in, tb_ff, tc_in, tc_ff, td_ff;
   logic [TERM_W-1:0]  sinp_mag;
   logic [55:0]        sq_in, sq_ff;
   logic [REM_W-1:0]   rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         wx_ff <= in_data.quat_w * in_data.quat_x;
         yz_ff <= in_data.quat_y * in_data.quat_z;
         xx_ff <= in_data.quat_x * in_data.quat_x;
         yy_ff <= in_data.quat_y * in_data.quat_y;
         zz_ff <= in_data.quat_z * in_data.quat_z;
         wy_ff <= in_data.quat_w * in_data.quat_y;
         zx_ff <= in_data.quat_z * in_data.quat_x;
         wz_ff <= in_data.quat_w * in_data.quat_z;
         xy_ff <= in_data.quat_x * in_data.quat_y;
      end
   end

   always_comb begin
      tb_in.sinr  = (TERM_W'(wx_ff) + TERM_W'(yz_ff)) <<< 1;
      tb_in.cosr  = ONE_Q28 - ((TERM_W'(xx_ff) + TERM_W'(yy_ff)) <<< 1);
      tb_in.sinp  = (TERM_W'(wy_ff) - TERM_W'(zx_ff)) <<< 1;
      tb_in.siny  = (TERM_W'(wz_ff) + TERM_W'(xy_ff)) <<< 1;
      tb_in.cosy  = ONE_Q28 - ((TERM_W'(yy_ff) + TERM_W'(zz_ff)) <<< 1);
      tb_in.clamp = 1'b0;
   end

   // square only means something when |sinp| < 1, so 28 magnitude bits do
   always_comb begin
      tc_in       = tb_ff;
      tc_in.clamp = (tb_ff.sinp >= ONE_Q28) || (tb_ff.sinp <= -ONE_Q28);
      sinp_mag    = tb_ff.sinp[TERM_W-1] ? TERM_W'(-tb_ff.sinp) : TERM_W'(tb_ff.sinp);
      sq_in       = sinp_mag[27:0] * sinp_mag[27:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tb_ff  <= tb_in;
         tc_ff  <= tc_in;
         sq_ff  <= sq_in;
         td_ff  <= tc_ff;
         rem_ff <= ONE_Q56 - {1'b0, sq_ff};
      end
   end

   assign out_valid = valid_ff[3];
   assign out_terms = td_ff;
   assign out_rem   = rem_ff;

endmodule

>>> rtl/qte_isqrt.sv
// Pipelined floor square root, one result bit per stage, with side data.
`timescale 1ns / 1ps
module qte_isqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  qte_pkg::terms_type         in_terms,
   input  logic [qte_pkg::REM_W-1:0]  in_rem,
   output logic                       out_valid,
   output qte_pkg::terms_type         out_terms,
   output logic [qte_pkg::ROOT_W-1:0] out_root
);
   import qte_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [REM_W-1:0]      v_ff   [SQRT_STEPS];
   logic [REM_W:0]        res_ff [SQRT_STEPS];
   terms_type             t_ff   [SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[SQRT_STEPS-2:0], in_valid};
      end
   end

   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      localparam logic [REM_W:0] STEP_BIT = (REM_W+1)'(1) << (2 * (SQRT_STEPS - 1 - j));
      logic [REM_W-1:0] v_prev, v_in;
      logic [REM_W:0]   res_prev, res_in, trial;
      terms_type        t_prev;

      if (j == 0) begin : g_first
         assign v_prev   = in_rem;
         assign res_prev = '0;
         assign t_prev   = in_terms;
      end else begin : g_next
         assign v_prev   = v_ff[j-1];
         assign res_prev = res_ff[j-1];
         assign t_prev   = t_ff[j-1];
      end

      always_comb begin
         trial = res_prev + STEP_BIT;
         if ({1'b0, v_prev} >= trial) begin
            v_in   = v_prev - trial[REM_W-1:0];
            res_in = (res_prev >> 1) + STEP_BIT;
         end else begin
            v_in   = v_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[j]   <= v_in;
            res_ff[j] <= res_in;
            t_ff[j]   <= t_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_terms = t_ff[SQRT_STEPS-1];
   assign out_root  = res_ff[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

>>> rtl/qte_atan2.sv
// Pipelined atan2: quadrant fold, two normalize stages, CORDIC stages, rounding.
`timescale 1ns / 1ps
module qte_atan2 (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [qte_pkg::ATAN_IN_W-1:0] in_y,
   input  logic signed [qte_pkg::ATAN_IN_W-1:0] in_x,
   input  logic [1:0]                           in_tag,
   output logic                                 out_valid,
   output logic signed [15:0]                   out_angle,
   output logic [1:0]                           out_tag
);
   import qte_pkg::*;

   typedef struct packed {
      logic       yzero;
      logic       xneg;
      logic [1:0] tag;
   } side_type;

   logic [ATAN_LAT-1:0] valid_ff;
   side_type            side_in;
   side_type            side_ff [ATAN_LAT];

   logic signed [CW-1:0] x_ext, y_ext, xp_in, yp_in, xp_ff, yp_ff;
   logic signed [ZW-1:0] z0_in, z0_ff;

   logic signed [CW-1:0] n1x_in, n1y_in, n1x_ff, n1y_ff, n2x_in, n2y_in, n2x_ff, n2y_ff;
   logic [CW-1:0]        ax, ay, n1m_in, n1m_ff, n2m;
   logic signed [ZW-1:0] n1z_ff, n2z_ff;

   logic signed [CW-1:0] cx_ff [CORDIC_STAGES];
   logic signed [CW-1:0] cy_ff [CORDIC_STAGES];
   logic signed [ZW-1:0] cz_ff [CORDIC_STAGES];

   logic signed [ZW:0]    zsum;
   logic signed [ZW-11:0] zq;
   logic signed [15:0]    angle_in, angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ATAN_LAT-2:0], in_valid};
      end
   end

   // fold a negative x into the right half plane, starting from +-pi
   always_comb begin
      x_ext         = CW'(in_x);
      y_ext         = CW'(in_y);
      side_in.yzero = (in_y == '0);
      side_in.xneg  = in_x[ATAN_IN_W-1];
      side_in.tag   = in_tag;
      if (in_x[ATAN_IN_W-1]) begin
         xp_in = -x_ext;
         yp_in = -y_ext;
         z0_in = in_y[ATAN_IN_W-1] ? -PI_Q24 : PI_Q24;
      end else begin
         xp_in = x_ext;
         yp_in = y_ext;
         z0_in = '0;
      end
   end

   // leading-zero normalization, coarse shifts then fine shifts
   always_comb begin
      ax     = xp_ff[CW-1] ? CW'(-xp_ff) : CW'(xp_ff);
      ay     = yp_ff[CW-1] ? CW'(-yp_ff) : CW'(yp_ff);
      n1m_in = (ax > ay) ? ax : ay;
      n1x_in = xp_ff;
      n1y_in = yp_ff;
      for (int i = 0; i < 3; i++) begin
         if (n1m_in < (CW'(1) << (NORM_TOP + 1 - (32 >> i)))) begin
            n1m_in = n1m_in << (32 >> i);
            n1x_in = n1x_in <<< (32 >> i);
            n1y_in = n1y_in <<< (32 >> i);
         end
      end
   end

   always_comb begin
      n2m    = n1m_ff;
      n2x_in = n1x_ff;
      n2y_in = n1y_ff;
      for (int i = 0; i < 3; i++) begin
         if (n2m < (CW'(1) << (NORM_TOP + 1 - (4 >> i)))) begin
            n2m    = n2m << (4 >> i);
            n2x_in = n2x_in <<< (4 >> i);
            n2y_in = n2y_in <<< (4 >> i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         xp_ff      <= xp_in;
         yp_ff      <= yp_in;
         z0_ff      <= z0_in;
         side_ff[0] <= side_in;
         n1x_ff     <= n1x_in;
         n1y_ff     <= n1y_in;
         n1m_ff     <= n1m_in;
         n1z_ff     <= z0_ff;
         n2x_ff     <= n2x_in;
         n2y_ff     <= n2y_in;
         n2z_ff     <= n1z_ff;
      end
   end

   for (genvar k = 1; k < ATAN_LAT; k++) begin : g_side
      always_ff @(posedge clock) begin
         if (en) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      logic signed [CW-1:0] x_prev, y_prev, xs, ys;
      logic signed [ZW-1:0] z_prev;

      if (i == 0) begin : g_first
         assign x_prev = n2x_ff;
         assign y_prev = n2y_ff;
         assign z_prev = n2z_ff;
      end else begin : g_next
         assign x_prev = cx_ff[i-1];
         assign y_prev = cy_ff[i-1];
         assign z_prev = cz_ff[i-1];
      end

      assign xs = x_prev >>> i;
      assign ys = y_prev >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_prev[CW-1]) begin
               cx_ff[i] <= x_prev + ys;
               cy_ff[i] <= y_prev - xs;
               cz_ff[i] <= z_prev + $signed(ATAN_TABLE[i]);
            end else begin
               cx_ff[i] <= x_prev - ys;
               cy_ff[i] <= y_prev + xs;
               cz_ff[i] <= z_prev - $signed(ATAN_TABLE[i]);
            end
         end
      end
   end

   // round half up to Q13 and saturate to +-pi; a zero y gives 0 or pi directly
   always_comb begin
      zsum = (ZW+1)'(cz_ff[CORDIC_STAGES-1]) + (ZW+1)'(1024);
      zq   = zsum[ZW:11];
      if (side_ff[ATAN_LAT-2].yzero) begin
         angle_in = side_ff[ATAN_LAT-2].xneg ? PI_Q13 : '0;
      end else if (zq > PI_Q13) begin
         angle_in = PI_Q13;
      end else if (zq < -PI_Q13) begin
         angle_in = -PI_Q13;
      end else begin
         angle_in = zq[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         angle_ff <= angle_in;
      end
   end

   assign out_valid = valid_ff[ATAN_LAT-1];
   assign out_angle = angle_ff;
   assign out_tag   = side_ff[ATAN_LAT-1].tag;

endmodule
